// ===== src/scm_pkg.sv =====
// Shared types, constants and rounding helpers for the sine/cosine core.
// Used by scm_reduce, scm_horner_cell and sine_cosine_minimax_core.
package scm_pkg;

   localparam int NUM_TERMS = 6;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic signed [63:0] TWO_PI_Q52  = signed'((PI_Q60 + 64'h40) >> 7);
   localparam logic signed [63:0] PI_Q52      = signed'((PI_Q60 + 64'h80) >> 8);
   localparam logic signed [63:0] HALF_PI_Q52 = signed'((PI_Q60 + 64'h100) >> 9);
   localparam logic signed [31:0] INV_TWO_PI_Q33 = 32'sh517CC1B7;
   localparam logic signed [65:0] ONE_Q30 = 66'sd1073741824;

   localparam logic signed [32:0] SIN_COEF [NUM_TERMS] = '{
      -33'sd26, 33'sd2956, -33'sd213040, 33'sd8947846, -33'sd178956974, 33'sd1073741824
   };

   localparam logic signed [32:0] COS_COEF [NUM_TERMS] = '{
      -33'sd280, 33'sd26586, -33'sd1491253, 33'sd44739212, -33'sd536870912,
      33'sd1073741824
   };

   typedef struct packed {
      logic signed [32:0] acc_s;
      logic signed [32:0] acc_c;
      logic signed [32:0] y2;
      logic signed [31:0] y30;
      logic               flip;
   } scm_lane_type;

   // round to nearest, ties away from zero
   function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                      input int unsigned s);
      logic signed [65:0] half;
      logic signed [65:0] bias;
      half = 66'sd1 <<< (s - 1);
      bias = v[65] ? (half - 66'sd1) : half;
      return (v + bias) >>> s;
   endfunction

   function automatic logic signed [31:0] clamp_one(input logic signed [65:0] v);
      logic signed [65:0] r;
      if (v > ONE_Q30) begin
         r = ONE_Q30;
      end else if (v < -ONE_Q30) begin
         r = -ONE_Q30;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

endpackage

// ===== src/scm_reduce.sv =====
// Range reduction front end: quotient, 2*pi subtraction, fold, y and y^2.
// Depends on scm_pkg; feeds the first scm_horner_cell.
module scm_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [31:0]   in_angle,
   output logic                 out_valid,
   input  logic                 out_ready,
   output scm_pkg::scm_lane_type out_lane
);

   localparam int STAGES = 8;

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   rdy;
   logic [STAGES-1:0] ld;

   logic signed [31:0] a0_ff, a1_ff, a2_ff;
   logic signed [63:0] p_ff, p_in;
   logic signed [5:0]  q_ff, q_in;
   logic signed [63:0] y_ff, y_in;
   logic signed [63:0] yf_ff, yf_in;
   logic               flip4_ff, flip4_in, flip5_ff, flip6_ff;
   logic signed [31:0] y30_ff, y30_in, y30b_ff;
   logic signed [63:0] sq_ff, sq_in;
   scm_pkg::scm_lane_type lane_ff, lane_in;
   logic signed [65:0] q_round, y_round, y2_round;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      ld[0] = rdy[0] && in_valid;
      for (int k = 1; k < STAGES; k++) begin
         ld[k] = rdy[k] && v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign p_in    = a0_ff * scm_pkg::INV_TWO_PI_Q33;
   assign q_round = scm_pkg::round_shift(66'(p_ff), 57);
   assign q_in    = q_round[5:0];
   assign y_in    = (64'(a2_ff) <<< 28) - 64'(q_ff) * scm_pkg::TWO_PI_Q52;

   always_comb begin
      if (y_ff > scm_pkg::HALF_PI_Q52) begin
         yf_in    = scm_pkg::PI_Q52 - y_ff;
         flip4_in = 1'b1;
      end else if (y_ff < -scm_pkg::HALF_PI_Q52) begin
         yf_in    = -scm_pkg::PI_Q52 - y_ff;
         flip4_in = 1'b1;
      end else begin
         yf_in    = y_ff;
         flip4_in = 1'b0;
      end
   end

   assign y_round  = scm_pkg::round_shift(66'(yf_ff), 22);
   assign y30_in   = y_round[31:0];
   assign sq_in    = y30_ff * y30_ff;
   assign y2_round = scm_pkg::round_shift(66'(sq_ff), 30);

   always_comb begin
      lane_in.acc_s = scm_pkg::SIN_COEF[0];
      lane_in.acc_c = scm_pkg::COS_COEF[0];
      lane_in.y2    = y2_round[32:0];
      lane_in.y30   = y30b_ff;
      lane_in.flip  = flip6_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         a0_ff <= in_angle;
      end
      if (ld[1]) begin
         p_ff  <= p_in;
         a1_ff <= a0_ff;
      end
      if (ld[2]) begin
         q_ff  <= q_in;
         a2_ff <= a1_ff;
      end
      if (ld[3]) begin
         y_ff <= y_in;
      end
      if (ld[4]) begin
         yf_ff    <= yf_in;
         flip4_ff <= flip4_in;
      end
      if (ld[5]) begin
         y30_ff   <= y30_in;
         flip5_ff <= flip4_ff;
      end
      if (ld[6]) begin
         sq_ff    <= sq_in;
         y30b_ff  <= y30_ff;
         flip6_ff <= flip5_ff;
      end
      if (ld[7]) begin
         lane_ff <= lane_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_lane  = lane_ff;

endmodule

// ===== src/scm_horner_cell.sv =====
// One Horner step for sine and cosine: multiply by y^2, then round and add.
// Depends on scm_pkg; chained in sine_cosine_minimax_core.
module scm_horner_cell #(
   parameter int K = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  scm_pkg::scm_lane_type in_lane,
   output logic                  out_valid,
   input  logic                  out_ready,
   output scm_pkg::scm_lane_type out_lane
);

   logic               mv_ff, av_ff;
   logic               m_rdy, a_rdy;
   logic signed [65:0] ps_ff, pc_ff, ps_in, pc_in;
   logic signed [65:0] rs, rc;
   scm_pkg::scm_lane_type ml_ff, al_ff, al_in;

   assign a_rdy = !av_ff || out_ready;
   assign m_rdy = !mv_ff || a_rdy;

   assign ps_in = in_lane.acc_s * in_lane.y2;
   assign pc_in = in_lane.acc_c * in_lane.y2;
   assign rs    = scm_pkg::round_shift(ps_ff, 30);
   assign rc    = scm_pkg::round_shift(pc_ff, 30);

   always_comb begin
      al_in       = ml_ff;
      al_in.acc_s = rs[32:0] + scm_pkg::SIN_COEF[K];
      al_in.acc_c = rc[32:0] + scm_pkg::COS_COEF[K];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         av_ff <= 1'b0;
      end else begin
         if (m_rdy) begin
            mv_ff <= in_valid;
         end
         if (a_rdy) begin
            av_ff <= mv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_rdy && in_valid) begin
         ps_ff <= ps_in;
         pc_ff <= pc_in;
         ml_ff <= in_lane;
      end
      if (a_rdy && mv_ff) begin
         al_ff <= al_in;
      end
   end

   assign in_ready  = m_rdy;
   assign out_valid = av_ff;
   assign out_lane  = al_ff;

endmodule

// ===== src/sine_cosine_minimax_core.sv =====
// Sine/cosine core: range reduction, a row of Horner cells, output stage.
// Depends on scm_pkg, scm_reduce and scm_horner_cell.
//
// Takes one Q8.24 angle word per cycle while req_stall is low and returns
// its sine and cosine in Q2.30, saturated to plus or minus one. scm_reduce
// registers range reduction and y^2, each of the 5 Horner cells registers
// its product then its sum, and the sine product and saturation come last.
// Every stage has its own valid bit and stalls only when the stage after
// it is full, so bubbles collapse while rsp_stall is high.
module sine_cosine_minimax_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sine,
   output logic signed [31:0] rsp_cosine
);

   localparam int CELLS = scm_pkg::NUM_TERMS - 1;

   scm_pkg::scm_lane_type lane [CELLS+1];
   logic [CELLS:0] lv;
   logic [CELLS:0] lr;
   logic           red_ready;

   scm_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (red_ready),
      .in_angle  (req_angle),
      .out_valid (lv[0]),
      .out_ready (lr[0]),
      .out_lane  (lane[0])
   );

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      scm_horner_cell #(
         .K (k + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lv[k]),
         .in_ready  (lr[k]),
         .in_lane   (lane[k]),
         .out_valid (lv[k+1]),
         .out_ready (lr[k+1]),
         .out_lane  (lane[k+1])
      );
   end

   logic               fv_ff, ov_ff;
   logic               f_rdy, o_rdy;
   logic signed [65:0] ps_ff, ps_in, rs;
   logic signed [33:0] cp_ff, cp_in;
   logic signed [31:0] sine_ff, cosine_ff;

   assign o_rdy = !ov_ff || !rsp_stall;
   assign f_rdy = !fv_ff || o_rdy;
   assign lr[CELLS] = f_rdy;

   assign ps_in = lane[CELLS].acc_s * lane[CELLS].y30;
   assign cp_in = lane[CELLS].flip ? -34'(lane[CELLS].acc_c) : 34'(lane[CELLS].acc_c);
   assign rs    = scm_pkg::round_shift(ps_ff, 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (f_rdy) begin
            fv_ff <= lv[CELLS];
         end
         if (o_rdy) begin
            ov_ff <= fv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_rdy && lv[CELLS]) begin
         ps_ff <= ps_in;
         cp_ff <= cp_in;
      end
      if (o_rdy && fv_ff) begin
         sine_ff   <= scm_pkg::clamp_one(rs);
         cosine_ff <= scm_pkg::clamp_one(66'(cp_ff));
      end
   end

   assign req_stall  = !red_ready;
   assign rsp_valid  = ov_ff;
   assign rsp_sine   = sine_ff;
   assign rsp_cosine = cosine_ff;

endmodule
